// ===== hw/rtl/dcoc_pkg.sv =====
// Shared types and constants for the distinct color occurrence counter.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package dcoc_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths of the stream words.
  localparam int COMP_W   = 8;
  localparam int COLOR_W  = 4 * COMP_W;
  localparam int ENTRY_W  = 10;
  localparam int OCC_W    = 32;
  localparam int TOTAL_W  = 11;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 88;
  localparam int M_USER_W = 3;

  // Input tuser code.
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Output tuser bit positions.
  localparam int U_IS_NEW  = 0;
  localparam int U_DROPPED = 1;
  localparam int U_VALID   = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_e;

  typedef enum logic [1:0] {
    KIND_HIT,
    KIND_MISS,
    KIND_READ
  } res_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      issue;
    logic      rd_issue;
    logic      load;
    res_kind_e kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_read;
    logic hit;
    logic pend;
    logic exhausted;
  } status_t;

endpackage : dcoc_pkg

`default_nettype wire

// ===== hw/rtl/distinct_color_occurrence_counter.sv =====
// Top level of the distinct color occurrence counter.
// Depends on dcoc_pkg, dcoc_ctrl and dcoc_dp.
`default_nettype none

// The block counts occurrences of distinct RGBA colors in a table of up to
// 1024 entries and answers every input word with exactly one output word.
// A count word scans the used entries from position 0 with one memory read
// per cycle. A read word reads the requested entry and then loads its result.
// Words are processed one at a time. The next input word is taken in the
// cycle after a result is loaded, while that result still waits in the output
// register. A completion is held for as long as the output register keeps an
// untaken word. No clearing pass is needed after reset.
module distinct_color_occurrence_counter
  import dcoc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], read_index[41:32], zero pad
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // opcode[0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
  // entry_index[41:32], occurrence_count[73:42], distinct_total[84:74], zero pad
  output logic      [M_DATA_W-1:0] m_axis_tdata,
  // is_new[0], dropped[1], entry_valid[2]
  output logic      [M_USER_W-1:0] m_axis_tuser
);

  cmd_t    cmd;
  status_t status;

  dcoc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  dcoc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule : distinct_color_occurrence_counter

`default_nettype wire

// ===== hw/rtl/dcoc_ctrl.sv =====
// Controller state machine of the distinct color occurrence counter.
// Depends on dcoc_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module dcoc_ctrl
  import dcoc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_axis_tvalid,
  output logic         s_axis_tready,
  output logic         m_axis_tvalid,
  input  wire logic    m_axis_tready,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   load_ok;

  // The output register may be refilled once it is empty or being taken.
  assign load_ok = !out_vld_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (status_i.in_read == OP_READ) ? ST_RD_ADDR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_HIT;
        end else if (status_i.exhausted && !status_i.pend) begin
          state_d = ST_MISS;
        end
      end
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_HIT, ST_MISS, ST_RD_DATA: begin
        if (load_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = KIND_HIT;
    s_axis_tready  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      ST_SCAN: begin
        cmd_o.issue = !status_i.hit && !status_i.exhausted;
      end
      ST_RD_ADDR: cmd_o.rd_issue = 1'b1;
      ST_HIT: begin
        cmd_o.load = load_ok;
        cmd_o.kind = KIND_HIT;
      end
      ST_MISS: begin
        cmd_o.load = load_ok;
        cmd_o.kind = KIND_MISS;
      end
      ST_RD_DATA: begin
        cmd_o.load = load_ok;
        cmd_o.kind = KIND_READ;
      end
      default: cmd_o = '0;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule : dcoc_ctrl

`default_nettype wire

// ===== hw/rtl/dcoc_dp.sv =====
// Datapath of the distinct color occurrence counter: color and count memories,
// scan counter, compare, saturating increment and output word. Depends on dcoc_pkg.
`default_nettype none

module dcoc_dp
  import dcoc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  input  wire logic                s_axis_tuser,
  output logic      [M_DATA_W-1:0] m_axis_tdata,
  output logic      [M_USER_W-1:0] m_axis_tuser,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o
);

  // Captured input word.
  logic [COLOR_W-1:0] color_q;
  logic [ENTRY_W-1:0] ridx_q;

  // Scan and read state.
  logic [CNT_W-1:0]   used_q;
  logic [CNT_W-1:0]   scan_q;
  logic               pend_q;
  logic [IDX_W-1:0]   cmp_idx_q;

  // Memories with registered read data.
  logic [COLOR_W-1:0] color_mem [TABLE_DEPTH];
  logic [OCC_W-1:0]   count_mem [TABLE_DEPTH];
  logic [COLOR_W-1:0] rd_color_q;
  logic [OCC_W-1:0]   rd_count_q;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               col_we;
  logic               cnt_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [OCC_W-1:0]   cnt_wdata;
  logic               full;
  logic               hit;
  logic               rd_ok;
  logic [OCC_W-1:0]   cnt_inc;

  // Result registers.
  logic [COLOR_W-1:0] res_color_q, res_color_d;
  logic [ENTRY_W-1:0] res_index_q, res_index_d;
  logic [OCC_W-1:0]   res_count_q, res_count_d;
  logic [M_USER_W-1:0] res_flags_q, res_flags_d;
  logic [CNT_W-1:0]   used_d;

  assign full    = (used_q == CNT_W'(TABLE_DEPTH));
  assign hit     = pend_q && (rd_color_q == color_q);
  assign cnt_inc = (rd_count_q == '1) ? rd_count_q : rd_count_q + 1'b1;
  assign rd_ok   = (32'(ridx_q) < 32'(used_q)) && (32'(ridx_q) < 32'(TABLE_DEPTH));

  assign status_o.in_read   = s_axis_tuser;
  assign status_o.hit       = hit;
  assign status_o.pend      = pend_q;
  assign status_o.exhausted = (scan_q == used_q);

  // Read address: scan position or the requested entry.
  assign rd_en   = cmd_i.issue || cmd_i.rd_issue;
  assign rd_addr = cmd_i.rd_issue ? IDX_W'(ridx_q) : scan_q[IDX_W-1:0];

  // Write port: a hit rewrites the count, an append writes both memories.
  always_comb begin
    col_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_addr   = cmp_idx_q;
    cnt_wdata = cnt_inc;
    if (cmd_i.load && cmd_i.kind == KIND_HIT) begin
      cnt_we = 1'b1;
    end else if (cmd_i.load && cmd_i.kind == KIND_MISS && !full) begin
      col_we    = 1'b1;
      cnt_we    = 1'b1;
      wr_addr   = used_q[IDX_W-1:0];
      cnt_wdata = OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      color_mem[wr_addr] <= color_q;
    end
    if (rd_en) begin
      rd_color_q <= color_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      count_mem[wr_addr] <= cnt_wdata;
    end
    if (rd_en) begin
      rd_count_q <= count_mem[rd_addr];
    end
  end

  // Result word for each kind of completion.
  always_comb begin
    used_d      = used_q;
    res_color_d = color_q;
    res_index_d = ENTRY_W'(cmp_idx_q);
    res_count_d = cnt_inc;
    res_flags_d = '0;
    res_flags_d[U_VALID] = 1'b1;
    case (cmd_i.kind)
      KIND_HIT: ;
      KIND_MISS: begin
        if (full) begin
          res_index_d            = '0;
          res_count_d            = '0;
          res_flags_d[U_VALID]   = 1'b0;
          res_flags_d[U_DROPPED] = 1'b1;
        end else begin
          res_index_d           = ENTRY_W'(used_q);
          res_count_d           = OCC_W'(1);
          res_flags_d[U_IS_NEW] = 1'b1;
          used_d                = used_q + 1'b1;
        end
      end
      KIND_READ: begin
        res_index_d          = ridx_q;
        res_color_d          = rd_ok ? rd_color_q : '0;
        res_count_d          = rd_ok ? rd_count_q : '0;
        res_flags_d[U_VALID] = rd_ok;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      scan_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.issue;
      if (cmd_i.capture) begin
        scan_q <= '0;
      end else if (cmd_i.issue) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.load) begin
        used_q <= used_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      color_q <= {s_axis_tdata[7:0], s_axis_tdata[15:8],
                  s_axis_tdata[23:16], s_axis_tdata[31:24]};
      ridx_q  <= s_axis_tdata[41:32];
    end
    if (cmd_i.issue) begin
      cmp_idx_q <= scan_q[IDX_W-1:0];
    end
    if (cmd_i.load) begin
      res_color_q <= res_color_d;
      res_index_q <= res_index_d;
      res_count_q <= res_count_d;
      res_flags_q <= res_flags_d;
    end
  end

  // Output word: red, green, blue, alpha, entry_index, occurrence_count,
  // distinct_total from the lowest bit up.
  assign m_axis_tdata = {3'b000, TOTAL_W'(used_q), res_count_q, res_index_q,
                         res_color_q[7:0], res_color_q[15:8],
                         res_color_q[23:16], res_color_q[31:24]};
  assign m_axis_tuser = res_flags_q;

endmodule : dcoc_dp

`default_nettype wire

// ===== hw/rtl/dcoc_checker.sv =====
// Port-level checker for the distinct color occurrence counter and its bind.
// Depends on dcoc_pkg and the top-level port list.
`default_nettype none

module dcoc_checker
  import dcoc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [M_DATA_W-1:0] m_axis_tdata,
  input wire logic [M_USER_W-1:0] m_axis_tuser
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word withdrawn while stalled");

  // One word is worked on at a time, so input is closed right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // A newly appended entry is valid and has a count of one.
  a_new_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[U_IS_NEW] |->
      m_axis_tuser[U_VALID] && !m_axis_tuser[U_DROPPED] &&
      m_axis_tdata[73:42] == 32'd1)
    else $error("new entry reported with wrong flags or count");

  // A dropped color reports no entry, a zero count and a full table.
  a_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[U_DROPPED] |->
      !m_axis_tuser[U_VALID] && m_axis_tdata[73:42] == 32'd0 &&
      m_axis_tdata[84:74] == 11'd1024)
    else $error("drop reported with a table that is not full");

endmodule : dcoc_checker

bind distinct_color_occurrence_counter dcoc_checker u_dcoc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/distinct_color_occurrence_counter_test.sv =====
// Self-checking testbench for the distinct color occurrence counter.
// It predicts every result word from its own copy of the color table and compares.
// Depends on dcoc_pkg and the distinct_color_occurrence_counter top level.
`default_nettype none

module distinct_color_occurrence_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcoc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = TABLE_DEPTH + 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_WORDS   = 195;

  // One predicted result word, split into its fields.
  typedef struct packed {
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [COMP_W-1:0]  alpha;
    logic [ENTRY_W-1:0] entry_index;
    logic [OCC_W-1:0]   occurrence_count;
    logic               is_new;
    logic               dropped;
    logic               entry_valid;
    logic [TOTAL_W-1:0] distinct_total;
  } tally_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                s_axis_tuser  = OP_COUNT;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;

  // Predicted table contents and the results still owed by the block.
  logic [COLOR_W-1:0] seen_color [TABLE_DEPTH];
  logic [OCC_W-1:0]   seen_count [TABLE_DEPTH];
  int unsigned        seen_used = 0;
  tally_t             expected_tallies [$];
  logic [COLOR_W-1:0] palette [$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_count     = 0;
  int quiet_cycles   = 0;

  always #5 clk_i = ~clk_i;

  distinct_color_occurrence_counter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Position of the first stored entry holding this color, or -1.
  function automatic int find_color(input logic [COLOR_W-1:0] color);
    for (int k = 0; k < seen_used; k++) begin
      if (seen_color[k] == color) return k;
    end
    return -1;
  endfunction

  // A random color that the table does not hold yet.
  function automatic logic [COLOR_W-1:0] fresh_color();
    logic [COLOR_W-1:0] color;
    do color = $urandom; while (find_color(color) >= 0);
    return color;
  endfunction

  // Updates the predicted table for one accepted word and returns its result.
  function automatic tally_t predict_tally(input logic op, input logic [COLOR_W-1:0] color,
                                           input logic [ENTRY_W-1:0] ridx);
    tally_t t;
    int     hit;
    t = '0;
    if (op == OP_READ) begin
      t.entry_index = ridx;
      if (ridx < seen_used) begin
        {t.red, t.green, t.blue, t.alpha} = seen_color[ridx];
        t.occurrence_count = seen_count[ridx];
        t.entry_valid      = 1'b1;
      end
    end else begin
      {t.red, t.green, t.blue, t.alpha} = color;
      hit = find_color(color);
      if (hit >= 0) begin
        // Counts stick at their maximum.
        if (seen_count[hit] != '1) seen_count[hit] = seen_count[hit] + 1;
        t.entry_index      = hit[ENTRY_W-1:0];
        t.occurrence_count = seen_count[hit];
        t.entry_valid      = 1'b1;
      end else if (seen_used < TABLE_DEPTH) begin
        seen_color[seen_used] = color;
        seen_count[seen_used] = 1;
        t.entry_index         = seen_used[ENTRY_W-1:0];
        t.occurrence_count    = 1;
        t.is_new              = 1'b1;
        t.entry_valid         = 1'b1;
        seen_used++;
      end else begin
        t.dropped = 1'b1;
      end
    end
    t.distinct_total = seen_used[TOTAL_W-1:0];
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [OCC_W-1:0] got,
                                 input logic [OCC_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  task automatic compare_tally(input tally_t got, input tally_t want);
    if (got.red !== want.red) report_mismatch("out_red", got.red, want.red);
    if (got.green !== want.green) report_mismatch("out_green", got.green, want.green);
    if (got.blue !== want.blue) report_mismatch("out_blue", got.blue, want.blue);
    if (got.alpha !== want.alpha) report_mismatch("out_alpha", got.alpha, want.alpha);
    if (got.entry_index !== want.entry_index) begin
      report_mismatch("entry_index", got.entry_index, want.entry_index);
    end
    if (got.occurrence_count !== want.occurrence_count) begin
      report_mismatch("occurrence_count", got.occurrence_count, want.occurrence_count);
    end
    if (got.is_new !== want.is_new) report_mismatch("is_new", got.is_new, want.is_new);
    if (got.dropped !== want.dropped) report_mismatch("dropped", got.dropped, want.dropped);
    if (got.entry_valid !== want.entry_valid) begin
      report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
    end
    if (got.distinct_total !== want.distinct_total) begin
      report_mismatch("distinct_total", got.distinct_total, want.distinct_total);
    end
  endtask

  // Offers one word after a random gap and records its result once accepted.
  task automatic send_word(input logic op, input logic [COLOR_W-1:0] color,
                           input logic [ENTRY_W-1:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= S_DATA_W'({ridx, color[7:0], color[15:8], color[23:16], color[31:24]});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_tallies.push_back(predict_tally(op, color, ridx));
  endtask

  // Stops offering words until every owed result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk_i);
  endtask

  // Empty-table reads, extreme colors, hits, near misses and reads at the edges.
  task automatic test_directed();
    send_word(OP_READ, 32'h0000_0000, 10'd0);
    send_word(OP_READ, 32'hFFFF_FFFF, 10'h3FF);
    send_word(OP_COUNT, 32'h0000_0000, 10'h3FF);
    send_word(OP_COUNT, 32'hFFFF_FFFF, 10'h000);
    send_word(OP_COUNT, 32'hFFFF_FFFF, 10'h155);
    send_word(OP_COUNT, 32'h0000_0000, 10'h2AA);
    // Colors that differ from a stored one in a single component are new; the last is sent twice.
    send_word(OP_COUNT, 32'hFEFF_FFFF, 10'd0);
    send_word(OP_COUNT, 32'hFFFE_FFFF, 10'd0);
    send_word(OP_COUNT, 32'hFFFF_FEFF, 10'd0);
    send_word(OP_COUNT, 32'hFFFF_FFFE, 10'd0);
    send_word(OP_COUNT, 32'hFFFF_FFFE, 10'd0);
    send_word(OP_READ, 32'hFFFF_FFFF, 10'd0);
    send_word(OP_READ, 32'h0000_0000, 10'd5);
    send_word(OP_READ, 32'hA5A5_A5A5, 10'd6);
    send_word(OP_READ, 32'h0000_0000, 10'h3FF);
    wait_drained();
  endtask

  // Mostly counts of recurring colors, some fresh colors and reads near the used range.
  task automatic test_random(input int send_pct, input int recv_pct, input int words);
    int                 roll;
    int unsigned        top;
    logic [COLOR_W-1:0] color;
    logic [ENTRY_W-1:0] ridx;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (words) begin
      roll  = $urandom_range(99);
      color = $urandom;
      ridx  = $urandom_range(1023);
      if (roll < 25) begin
        if ($urandom_range(3) != 0) begin
          top  = $urandom_range(seen_used + 3);
          ridx = (top > 1023) ? 10'h3FF : top[ENTRY_W-1:0];
        end
        send_word(OP_READ, color, ridx);
      end else begin
        if ($urandom_range(99) < 80) begin
          color = palette[$urandom_range(palette.size() - 1)];
        end else if ($urandom_range(1) == 0) begin
          palette.push_back(color);
        end
        send_word(OP_COUNT, color, ridx);
      end
    end
    wait_drained();
  endtask

  // The receiver stalls for a long stretch while words keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (8) begin
      send_word(OP_COUNT, palette[$urandom_range(palette.size() - 1)], $urandom_range(1023));
    end
    wait_drained();
  endtask

  // Fills the table, then checks drops, hits at both ends and reads of a full table.
  task automatic test_table_full();
    int roll;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (seen_used < TABLE_DEPTH) begin
      send_word(OP_COUNT, fresh_color(), $urandom_range(1023));
    end
    send_word(OP_COUNT, fresh_color(), 10'd0);
    send_word(OP_COUNT, seen_color[TABLE_DEPTH-1], 10'd0);
    send_word(OP_COUNT, 32'h0000_0000, 10'h3FF);
    send_word(OP_READ, 32'hFFFF_FFFF, 10'h3FF);
    send_word(OP_READ, 32'h0000_0000, 10'd0);
    repeat (12) begin
      roll = $urandom_range(2);
      if (roll == 0) begin
        send_word(OP_COUNT, fresh_color(), $urandom_range(1023));
      end else if (roll == 1) begin
        send_word(OP_COUNT, seen_color[$urandom_range(TABLE_DEPTH - 1)], $urandom_range(1023));
      end else begin
        send_word(OP_READ, $urandom, $urandom_range(1023));
      end
    end
    wait_drained();
  endtask

  // Receiver ready, with random stalls and the occasional long hold-off.
  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_count   = HOLD_CYCLES;
    end
    if (hold_count > 0) begin
      hold_count--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    tally_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.red              = m_axis_tdata[7:0];
      got.green            = m_axis_tdata[15:8];
      got.blue             = m_axis_tdata[23:16];
      got.alpha            = m_axis_tdata[31:24];
      got.entry_index      = m_axis_tdata[41:32];
      got.occurrence_count = m_axis_tdata[73:42];
      got.distinct_total   = m_axis_tdata[84:74];
      got.is_new           = m_axis_tuser[U_IS_NEW];
      got.dropped          = m_axis_tuser[U_DROPPED];
      got.entry_valid      = m_axis_tuser[U_VALID];
      if (expected_tallies.size() == 0) begin
        report_mismatch("word with nothing expected, entry_index", got.entry_index, '0);
      end else begin
        compare_tally(got, expected_tallies.pop_front());
      end
    end
  end

  // Ends the run when neither side moves a word for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    repeat (32) palette.push_back($urandom);

    test_directed();
    test_random(30, 83, RANDOM_WORDS);
    test_random(83, 30, RANDOM_WORDS);
    test_random(0, 0, RANDOM_WORDS);
    test_backpressure();
    test_table_full();

    // Let any stray word surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_tallies.size() != 0) begin
      report_mismatch("words never returned", expected_tallies.size(), '0);
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
